@@ hdl/tmp_pkg.sv @@
`default_nettype none

package tmp_pkg;

  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam logic [30:0] VEL_LIMIT_RESET    = 31'd98304;
  localparam logic [30:0] ACCELERATION_RESET = 31'd131072;

  // configuration register indexes
  localparam logic CFG_VEL_LIMIT    = 1'b0;
  localparam logic CFG_ACCELERATION = 1'b1;

  localparam logic CMD_TICK       = 1'b0;
  localparam logic CMD_SET_TARGET = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] target_position;
    logic [15:0]        elapsed_time;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [30:0]        velocity;
    logic               arrived;
  } out_word_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SET_TARGET,
    DP_DIST,
    DP_ARRIVE,
    DP_MUL_VV,
    DP_MUL_AD,
    DP_MUL_DV,
    DP_SPEED,
    DP_MUL_STEP,
    DP_MOVE,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd;       // captured item is a set-target
    logic done;      // axis has arrived
    logic near;      // distance below tolerance
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_MUL_AD,
    ST_MUL_DV,
    ST_SPEED,
    ST_MUL_STEP,
    ST_MOVE,
    ST_RESULT
  } ctrl_state_t;

endpackage

`default_nettype wire

@@ hdl/trapezoidal_motion_profile.sv @@
// A set-target, or a tick after arrival, goes from decode straight to the result
// state; a tick that snaps within tolerance passes through the check state; a full
// motion tick runs four products in turn through the single shared 32x32 multiplier.
// A new word is accepted only once the previous one has been loaded into the output.
// Synchronous active-low reset: position, target, speed and arrived go to zero,
// the velocity limit to 1.5 and acceleration to 2.0 (Q16.16).
`default_nettype none

module trapezoidal_motion_profile #(
  parameter int FRACTION_BITS = tmp_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  tmp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output tmp_pkg::out_word_t out_data,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire  [30:0]        cfg_data
);

  tmp_pkg::dp_cmd_t    cmd;
  tmp_pkg::dp_status_t status;

  tmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tmp_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/tmp_datapath.sv @@
`default_nettype none

module tmp_datapath #(
  parameter int FRACTION_BITS = tmp_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  tmp_pkg::in_word_t   in_data,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire  [30:0]         cfg_data,
  input  tmp_pkg::dp_cmd_t    cmd,
  output tmp_pkg::dp_status_t status,
  output logic                out_valid,
  input  wire                 out_stall,
  output tmp_pkg::out_word_t  out_data
);

  localparam logic [63:0] TOL_WIDE  = ((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000;
  localparam logic [31:0] TOLERANCE = TOL_WIDE[31:0];

  // captured item
  logic        cmd_r;
  logic [31:0] in_tgt_r;
  logic [15:0] dt_r;

  // axis state
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tgt_r, tgt_nxt;
  logic [30:0] speed_r, speed_nxt;
  logic        done_r, done_nxt;

  // working registers
  logic [31:0] dist_r;
  logic        fwd_r;
  logic [63:0] vv_r;
  logic        brake_r;
  logic [63:0] prod_r;

  logic [30:0] maxv_r;
  logic [30:0] accel_r;

  tmp_pkg::out_word_t out_r;
  logic               out_valid_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_nxt;
  logic [32:0] err;
  logic [32:0] err_neg;
  logic [63:0] shifted;
  logic [63:0] v64, m64, sum64, vnew;

  // shared 32x32 multiplier, one product per cycle
  always_comb begin
    mul_a = {1'b0, speed_r};
    mul_b = {1'b0, speed_r};
    unique case (cmd.op)
      tmp_pkg::DP_MUL_AD: begin
        mul_a = {1'b0, accel_r};
        mul_b = dist_r;
      end
      tmp_pkg::DP_MUL_DV: begin
        mul_a = {1'b0, accel_r};
        mul_b = {16'd0, dt_r};
      end
      tmp_pkg::DP_MUL_STEP: begin
        mul_a = {1'b0, speed_r};
        mul_b = {16'd0, dt_r};
      end
      default: begin
        mul_a = {1'b0, speed_r};
        mul_b = {1'b0, speed_r};
      end
    endcase
  end

  assign prod_nxt = 64'(mul_a) * 64'(mul_b);

  assign err     = $signed({tgt_r[31], tgt_r}) - $signed({pos_r[31], pos_r});
  assign err_neg = 33'd0 - err;
  assign shifted = prod_r >> FRACTION_BITS;

  // speed update: brake, accelerate with clamp, or cruise
  always_comb begin
    v64   = {33'd0, speed_r};
    m64   = {33'd0, maxv_r};
    sum64 = v64 + shifted;
    vnew  = v64;
    if (brake_r) begin
      vnew = (v64 > shifted) ? v64 - shifted : 64'd0;
    end else if (v64 < m64) begin
      vnew = (sum64 > m64) ? m64 : sum64;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    tgt_nxt   = tgt_r;
    speed_nxt = speed_r;
    done_nxt  = done_r;
    unique case (cmd.op)
      tmp_pkg::DP_SET_TARGET: begin
        tgt_nxt   = in_tgt_r;
        speed_nxt = 31'd0;
        done_nxt  = 1'b0;
      end
      tmp_pkg::DP_ARRIVE: begin
        pos_nxt   = tgt_r;
        speed_nxt = 31'd0;
        done_nxt  = 1'b1;
      end
      tmp_pkg::DP_SPEED: begin
        speed_nxt = vnew[30:0];
      end
      tmp_pkg::DP_MOVE: begin
        if (shifted >= {32'd0, dist_r}) begin
          pos_nxt   = tgt_r;
          speed_nxt = 31'd0;
          done_nxt  = 1'b1;
        end else if (fwd_r) begin
          pos_nxt = pos_r + shifted[31:0];
        end else begin
          pos_nxt = pos_r - shifted[31:0];
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 32'd0;
      tgt_r   <= 32'd0;
      speed_r <= 31'd0;
      done_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      tgt_r   <= tgt_nxt;
      speed_r <= speed_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxv_r  <= tmp_pkg::VEL_LIMIT_RESET;
      accel_r <= tmp_pkg::ACCELERATION_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tmp_pkg::CFG_VEL_LIMIT) begin
        maxv_r <= cfg_data;
      end else begin
        accel_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tmp_pkg::DP_LOAD) begin
      cmd_r    <= in_data.cmd;
      in_tgt_r <= in_data.target_position;
      dt_r     <= in_data.elapsed_time;
    end
    if (cmd.op == tmp_pkg::DP_DIST) begin
      fwd_r  <= !err[32] && (err != 33'd0);
      dist_r <= err[32] ? err_neg[31:0] : err[31:0];
    end
    if (cmd.op == tmp_pkg::DP_MUL_VV || cmd.op == tmp_pkg::DP_MUL_AD ||
        cmd.op == tmp_pkg::DP_MUL_DV || cmd.op == tmp_pkg::DP_MUL_STEP) begin
      prod_r <= prod_nxt;
    end
    if (cmd.op == tmp_pkg::DP_MUL_AD) begin
      vv_r <= prod_r;
    end
    // prod_r holds a*dist here, below 2^63
    if (cmd.op == tmp_pkg::DP_MUL_DV) begin
      brake_r <= vv_r >= {prod_r[62:0], 1'b0};
    end
    if (cmd.op == tmp_pkg::DP_OUT) begin
      out_r.position <= pos_r;
      out_r.velocity <= speed_r;
      out_r.arrived  <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == tmp_pkg::DP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.cmd      = cmd_r;
  assign status.done     = done_r;
  assign status.near     = dist_r < TOLERANCE;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> pos_r == tgt_r)
    else $error("arrived but position differs from target");

  a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> speed_r == 31'd0)
    else $error("arrived with nonzero speed");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == tmp_pkg::DP_OUT |=> out_valid_r)
    else $error("output word not presented after load");

endmodule

`default_nettype wire

@@ hdl/tmp_ctrl.sv @@
`default_nettype none

module tmp_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  tmp_pkg::dp_status_t status,
  output tmp_pkg::dp_cmd_t    cmd
);

  tmp_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tmp_pkg::ST_DECODE;
      end
      tmp_pkg::ST_DECODE: begin
        if (status.cmd || status.done) state_nxt = tmp_pkg::ST_RESULT;
        else state_nxt = tmp_pkg::ST_CHECK;
      end
      tmp_pkg::ST_CHECK: begin
        if (status.near) state_nxt = tmp_pkg::ST_RESULT;
        else state_nxt = tmp_pkg::ST_MUL_AD;
      end
      tmp_pkg::ST_MUL_AD:   state_nxt = tmp_pkg::ST_MUL_DV;
      tmp_pkg::ST_MUL_DV:   state_nxt = tmp_pkg::ST_SPEED;
      tmp_pkg::ST_SPEED:    state_nxt = tmp_pkg::ST_MUL_STEP;
      tmp_pkg::ST_MUL_STEP: state_nxt = tmp_pkg::ST_MOVE;
      tmp_pkg::ST_MOVE:     state_nxt = tmp_pkg::ST_RESULT;
      tmp_pkg::ST_RESULT: begin
        if (status.out_free) state_nxt = tmp_pkg::ST_IDLE;
      end
      default: state_nxt = tmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = tmp_pkg::DP_NOP;
    in_stall = 1'b1;
    unique case (state_r)
      tmp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = tmp_pkg::DP_LOAD;
      end
      tmp_pkg::ST_DECODE: begin
        priority if (status.cmd) cmd.op = tmp_pkg::DP_SET_TARGET;
        else if (status.done) cmd.op = tmp_pkg::DP_NOP;
        else cmd.op = tmp_pkg::DP_DIST;
      end
      tmp_pkg::ST_CHECK: begin
        if (status.near) cmd.op = tmp_pkg::DP_ARRIVE;
        else cmd.op = tmp_pkg::DP_MUL_VV;
      end
      tmp_pkg::ST_MUL_AD:   cmd.op = tmp_pkg::DP_MUL_AD;
      tmp_pkg::ST_MUL_DV:   cmd.op = tmp_pkg::DP_MUL_DV;
      tmp_pkg::ST_SPEED:    cmd.op = tmp_pkg::DP_SPEED;
      tmp_pkg::ST_MUL_STEP: cmd.op = tmp_pkg::DP_MUL_STEP;
      tmp_pkg::ST_MOVE:     cmd.op = tmp_pkg::DP_MOVE;
      tmp_pkg::ST_RESULT: begin
        if (status.out_free) cmd.op = tmp_pkg::DP_OUT;
      end
      default: cmd.op = tmp_pkg::DP_NOP;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == tmp_pkg::ST_DECODE)
    else $error("accepted word not decoded");

  a_out_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == tmp_pkg::DP_OUT |-> status.out_free)
    else $error("output loaded while occupied");

  a_move_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tmp_pkg::ST_MOVE |=> state_r == tmp_pkg::ST_RESULT)
    else $error("move step not followed by result");

endmodule

`default_nettype wire
